// ----- hdl/tcma_pkg.sv -----
// Shared types and constants for the two-channel moving average.
// Holds the sequencer state type and the lane control bundle; no dependencies.
`timescale 1ns / 1ps

package tcma_pkg;

  localparam int CFG_WIDTH   = 7;
  localparam int INDEX_WIDTH = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_START,
    S_DIV,
    S_OUT
  } state_e;

  // Control bundle that the sequencer drives into every lane.
  typedef struct packed {
    logic capture;    // latch the new sample
    logic clear;      // empty the running sum
    logic rd_en;      // read the sample that leaves the window
    logic update;     // write the new sample and update the running sum
    logic use_old;    // subtract the sample read in the previous cycle
    logic div_start;  // begin the serial division of the running sum
  } lane_ctrl_t;

endpackage

// ----- hdl/two_channel_moving_average.sv -----
// The serial divider in each lane dominates the delay from input transfer to output valid.
// Inputs are taken only in the idle state, so a new sample is not accepted until the last one
// is through: until its result is loaded into the output register when a result is made, or
// until it is written when the window is still filling. A finished result waits in the output register.
// Reset: asynchronous, active low; window length 1, empty window, index 0.
// Depends on tcma_pkg, tcma_lane, tcma_merge.
`timescale 1ns / 1ps

module two_channel_moving_average #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcma_pkg::CFG_WIDTH-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]          drag_sample_i,
  input  logic [SAMPLE_WIDTH-1:0]          lift_sample_i,
  input  logic                             start_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]          drag_average_o,
  output logic [SAMPLE_WIDTH-1:0]          lift_average_o,
  output logic [tcma_pkg::INDEX_WIDTH-1:0] output_index_o
);
  import tcma_pkg::*;

  localparam int PW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);

  state_e state_q, state_d;

  logic [CFG_WIDTH-1:0]   wl_q, wl_d;
  logic [LW-1:0]          fill_q, fill_d;
  logic [PW-1:0]          wp_q, wp_d;
  logic [INDEX_WIDTH-1:0] cnt_q, cnt_d;
  logic                   use_old_q, use_old_d;

  logic [LW-1:0]   len;
  logic            full;
  logic [LW:0]     wp_ext, len_ext;
  logic [PW-1:0]   old_addr, wp_next;
  logic [LW-1:0]   fill_post;
  logic            accept;
  logic            can_load, load;
  logic            drag_done, lift_done;
  lane_ctrl_t      ctrl;
  logic [SAMPLE_WIDTH-1:0] drag_avg, lift_avg;

  // Length zero counts as one, and anything past the delay line as its depth.
  always_comb begin
    if (wl_q == '0) begin
      len = LW'(1);
    end else if (32'(wl_q) > 32'(MAX_WINDOW)) begin
      len = LW'(MAX_WINDOW);
    end else begin
      len = LW'(wl_q);
    end
  end

  assign full    = (fill_q >= len);
  assign wp_ext  = (LW + 1)'(wp_q);
  assign len_ext = (LW + 1)'(len);
  assign old_addr = (wp_ext >= len_ext) ? PW'(wp_ext - len_ext)
                                        : PW'(wp_ext + (LW + 1)'(MAX_WINDOW) - len_ext);
  assign wp_next   = (32'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + 1'b1;
  assign fill_post = use_old_q ? fill_q : fill_q + 1'b1;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ:   state_d = S_UPDATE;
      S_UPDATE: state_d = (fill_post >= len) ? S_START : S_IDLE;
      S_START:  state_d = S_DIV;
      S_DIV: begin
        if (drag_done && lift_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (can_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and window bookkeeping.
  always_comb begin
    ctrl      = '0;
    load      = 1'b0;
    wl_d      = wl_q;
    fill_d    = fill_q;
    wp_d      = wp_q;
    cnt_d     = cnt_q;
    use_old_d = use_old_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          wl_d       = cfg_wdata_i;
          ctrl.clear = 1'b1;
          fill_d     = '0;
          wp_d       = '0;
          cnt_d      = '0;
        end else if (accept) begin
          ctrl.capture = 1'b1;
          if (start_req_i) begin
            ctrl.clear = 1'b1;
            fill_d     = '0;
            wp_d       = '0;
            cnt_d      = '0;
          end
        end
      end
      S_READ: begin
        ctrl.rd_en = full;
        use_old_d  = full;
      end
      S_UPDATE: begin
        ctrl.update  = 1'b1;
        ctrl.use_old = use_old_q;
        wp_d         = wp_next;
        fill_d       = fill_post;
      end
      S_START: begin
        ctrl.div_start = 1'b1;
      end
      S_DIV: begin
      end
      S_OUT: begin
        if (can_load) begin
          load  = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wl_q      <= CFG_WIDTH'(1);
      fill_q    <= '0;
      wp_q      <= '0;
      cnt_q     <= '0;
      use_old_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wl_q      <= wl_d;
      fill_q    <= fill_d;
      wp_q      <= wp_d;
      cnt_q     <= cnt_d;
      use_old_q <= use_old_d;
    end
  end

  tcma_lane #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_drag_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sample_i  (drag_sample_i),
    .rd_addr_i (old_addr),
    .wr_addr_i (wp_q),
    .len_i     (len),
    .avg_o     (drag_avg),
    .done_o    (drag_done)
  );

  tcma_lane #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lift_lane (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sample_i  (lift_sample_i),
    .rd_addr_i (old_addr),
    .wr_addr_i (wp_q),
    .len_i     (len),
    .avg_o     (lift_avg),
    .done_o    (lift_done)
  );

  tcma_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .drag_i      (drag_avg),
    .lift_i      (lift_avg),
    .index_i     (cnt_q),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drag_o      (drag_average_o),
    .lift_o      (lift_average_o),
    .index_o     (output_index_o)
  );

endmodule

// ----- hdl/tcma_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module tcma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tcma_lane.sv -----
// One averaging lane: delay line, running sum and a restoring serial divider.
// Depends on tcma_pkg and tcma_ram.
`timescale 1ns / 1ps

module tcma_lane #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcma_pkg::lane_ctrl_t              ctrl_i,
  input  logic [SAMPLE_WIDTH-1:0]           sample_i,
  input  logic [$clog2(MAX_WINDOW)-1:0]     rd_addr_i,
  input  logic [$clog2(MAX_WINDOW)-1:0]     wr_addr_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]   len_i,
  output logic [SAMPLE_WIDTH-1:0]           avg_o,
  output logic                              done_o
);
  import tcma_pkg::*;

  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + PW;
  localparam int CW    = $clog2(SUM_W + 1);

  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic [SAMPLE_WIDTH-1:0] old_data;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [SUM_W-1:0]        old_ext, new_ext;

  logic [SUM_W-1:0] dvd_q, dvd_d;
  logic [LW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [LW:0]      trial;
  logic             qbit;
  logic [SUM_W-1:0] quot;

  tcma_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.update),
    .waddr_i (wr_addr_i),
    .wdata_i (sample_q),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (old_data)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      sample_q <= sample_i;
    end
  end

  assign old_ext = {{PW{old_data[SAMPLE_WIDTH-1]}}, old_data};
  assign new_ext = {{PW{sample_q[SAMPLE_WIDTH-1]}}, sample_q};

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.update) begin
      sum_d = sum_q + new_ext - (ctrl_i.use_old ? old_ext : '0);
    end
  end

  // One quotient bit per cycle on the magnitude of the sum.
  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, len_i});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    if (ctrl_i.div_start) begin
      neg_d  = sum_q[SUM_W-1];
      dvd_d  = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
      rem_d  = '0;
      cnt_d  = CW'(SUM_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = qbit ? LW'(trial - {1'b0, len_i}) : LW'(trial);
      dvd_d = {dvd_q[SUM_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign quot   = neg_q ? (~dvd_q + 1'b1) : dvd_q;
  assign avg_o  = quot[SAMPLE_WIDTH-1:0];
  assign done_o = done_q;

endmodule

// ----- hdl/tcma_merge.sv -----
// Output stage that joins both lane averages and the index into one transfer.
// Depends on tcma_pkg for the index width.
`timescale 1ns / 1ps

module tcma_merge #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic [SAMPLE_WIDTH-1:0]              drag_i,
  input  logic [SAMPLE_WIDTH-1:0]              lift_i,
  input  logic [tcma_pkg::INDEX_WIDTH-1:0]     index_i,
  output logic                                 can_load_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]              drag_o,
  output logic [SAMPLE_WIDTH-1:0]              lift_o,
  output logic [tcma_pkg::INDEX_WIDTH-1:0]     index_o
);
  import tcma_pkg::*;

  logic                    valid_q;
  logic [SAMPLE_WIDTH-1:0] drag_q, lift_q;
  logic [INDEX_WIDTH-1:0]  index_q;

  // The register is free when it is empty or its result transfers this cycle.
  assign can_load_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drag_q  <= drag_i;
      lift_q  <= lift_i;
      index_q <= index_i;
    end
  end

  assign out_valid_o = valid_q;
  assign drag_o      = drag_q;
  assign lift_o      = lift_q;
  assign index_o     = index_q;

endmodule
